/* hw/rtl/move_toward_target_step_macros.svh */
// ----------------------------------------------------------------------------
// move_toward_target_step_macros : assertion helpers
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MOVE_TOWARD_TARGET_STEP_MACROS_SVH
`define MOVE_TOWARD_TARGET_STEP_MACROS_SVH

// Implication in the same cycle
`define MTTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle
`define MTTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mtts_pkg.sv */
// ----------------------------------------------------------------------------
// mtts_pkg
// Types, widths and helpers for the move-toward-target pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtts_pkg;

  localparam int CW       = 32;          // coordinate width
  localparam int FracBits = 16;
  localparam int SpdW     = CW - 1;
  localparam int DtW      = 16;
  localparam int EpsRaw   = ((1 << FracBits) + 999999) / 1000000;

  typedef struct packed {
    logic          active;
    logic          physics_owned;
    logic          body_ready;
    logic [CW-1:0] target_x;
    logic [CW-1:0] target_y;
    logic [CW-1:0] target_z;
    logic [CW-1:0] pos_x;
    logic [CW-1:0] pos_y;
    logic [CW-1:0] pos_z;
    logic [SpdW-1:0] max_speed;
    logic [DtW-1:0]  delta_time;
  } mtts_in_t;

  typedef struct packed {
    logic [CW-1:0] new_pos_x;
    logic [CW-1:0] new_pos_y;
    logic [CW-1:0] new_pos_z;
    logic [CW-1:0] vel_x;
    logic [CW-1:0] vel_y;
    logic [CW-1:0] vel_z;
    logic          write_position;
    logic          write_velocity;
    logic          still_active;
  } mtts_out_t;

  // payload through the square root
  typedef struct packed {
    logic                act;
    logic                phys;
    logic                rdy;
    logic [2:0][CW-1:0]  tgt;
    logic [2:0][CW-1:0]  pos;
    logic [2:0][CW-1:0]  d;
    logic [SpdW-1:0]     spd;
    logic [SpdW-1:0]     step;
  } mtts_pl_t;

  // payload through the dividers
  typedef struct packed {
    logic                act;
    logic                phys;
    logic                rdy;
    logic                arrived;
    logic [2:0][CW-1:0]  tgt;
    logic [2:0][CW-1:0]  pos;
    logic [2:0][CW-1:0]  d;
  } mtts_p2_t;

  function automatic logic [CW-1:0] mtts_sat(logic signed [CW:0] v);
    logic signed [CW:0] hi;
    logic signed [CW:0] lo;
    hi = {2'b00, {(CW-1){1'b1}}};
    lo = {2'b11, {(CW-1){1'b0}}};
    if (v > hi) return hi[CW-1:0];
    else if (v < lo) return lo[CW-1:0];
    else return v[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] mtts_mag(logic [CW-1:0] v);
    return v[CW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/move_toward_target_step.sv */
// Stages from input beat to result: 3 front stages, 32 square root stages,
// 1 scale stage, 31 divider stages, output register.
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// Reset: asynchronous, active low, clears all valid bits; no data is reset.
// ----------------------------------------------------------------------------
// move_toward_target_step
// One tick of move-toward-target per entity: difference, distance, snap or
// scaled move / velocity, all signed fixed point with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "move_toward_target_step_macros.svh"

module move_toward_target_step
  import mtts_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire mtts_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output mtts_out_t      out_data_o
);

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 1: saturated difference and step length
  mtts_pl_t s1_d, s1_q;
  logic     s1_v_q;

  always_comb begin
    logic [SpdW+DtW-1:0] prod;
    s1_d.act  = in_data_i.active;
    s1_d.phys = in_data_i.physics_owned;
    s1_d.rdy  = in_data_i.body_ready;
    s1_d.tgt  = {in_data_i.target_z, in_data_i.target_y, in_data_i.target_x};
    s1_d.pos  = {in_data_i.pos_z, in_data_i.pos_y, in_data_i.pos_x};
    for (int a = 0; a < 3; a++) begin
      s1_d.d[a] = mtts_sat($signed({s1_d.tgt[a][CW-1], s1_d.tgt[a]})
                         - $signed({s1_d.pos[a][CW-1], s1_d.pos[a]}));
    end
    s1_d.spd  = in_data_i.max_speed;
    prod      = in_data_i.max_speed * in_data_i.delta_time;
    s1_d.step = prod[SpdW+15:16];
  end

  // stage 2: squares
  mtts_pl_t              s2_q;
  logic                  s2_v_q;
  logic [2:0][2*CW-1:0]  sq_q;

  // stage 3: sum of squares
  mtts_pl_t        s3_q;
  logic            s3_v_q;
  logic [2*CW-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      for (int a = 0; a < 3; a++) begin
        sq_q[a] <= mtts_mag(s1_q.d[a]) * mtts_mag(s1_q.d[a]);
      end
      s3_q  <= s2_q;
      sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  logic                       sq_v;
  logic [CW-1:0]              root_dist;
  logic [$bits(mtts_pl_t)-1:0] sq_pl;
  mtts_pl_t                   sq_p;

  mtts_sqrt #(.PW($bits(mtts_pl_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .rad_i   (sum_q),
    .pl_i    (s3_q),
    .valid_o (sq_v),
    .root_o  (root_dist),
    .pl_o    (sq_pl)
  );
  assign sq_p = mtts_pl_t'(sq_pl);

  // stage 4: arrival test and numerators |d| * k
  mtts_p2_t             s4_q;
  logic                 s4_v_q;
  logic [2:0][2*CW-3:0] num_q;
  logic [CW-1:0]        dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [SpdW-1:0] k;
    logic [2*CW-2:0] prod;
    if (en) begin
      k            = sq_p.phys ? sq_p.spd : sq_p.step;
      s4_q.act     <= sq_p.act;
      s4_q.phys    <= sq_p.phys;
      s4_q.rdy     <= sq_p.rdy;
      s4_q.arrived <= (root_dist <= {1'b0, sq_p.step}) || (root_dist < CW'(EpsRaw));
      s4_q.tgt     <= sq_p.tgt;
      s4_q.pos     <= sq_p.pos;
      s4_q.d       <= sq_p.d;
      for (int a = 0; a < 3; a++) begin
        prod     = mtts_mag(sq_p.d[a]) * k;
        num_q[a] <= prod[2*CW-3:0];
      end
      dist_q <= root_dist;
    end
  end

  logic                        dv_v;
  logic [2:0][CW-2:0]          quo;
  logic [$bits(mtts_p2_t)-1:0] dv_pl;
  mtts_p2_t                    dv_p;

  mtts_div #(.PW($bits(mtts_p2_t))) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_v_q),
    .num_i   (num_q),
    .den_i   (dist_q),
    .pl_i    (s4_q),
    .valid_o (dv_v),
    .quo_o   (quo),
    .pl_o    (dv_pl)
  );
  assign dv_p = mtts_p2_t'(dv_pl);

  // output stage
  mtts_out_t out_d, out_q;
  logic      out_v_q;

  always_comb begin
    logic [2:0][CW-1:0] np;
    logic [2:0][CW-1:0] vel;
    logic [2:0][CW-1:0] sq;
    logic               live;
    np   = '0;
    vel  = '0;
    live = dv_p.act && !(dv_p.phys && !dv_p.rdy);
    out_d.write_position = 1'b0;
    out_d.write_velocity = 1'b0;
    out_d.still_active   = dv_p.act;
    for (int a = 0; a < 3; a++) begin
      sq[a] = dv_p.d[a][CW-1] ? (~{1'b0, quo[a]} + 1'b1) : {1'b0, quo[a]};
    end
    if (live) begin
      if (dv_p.arrived) begin
        np = dv_p.tgt;
        out_d.write_position = 1'b1;
        out_d.write_velocity = dv_p.phys;
        out_d.still_active   = 1'b0;
      end else if (dv_p.phys) begin
        vel = sq;
        out_d.write_velocity = 1'b1;
      end else begin
        for (int a = 0; a < 3; a++) begin
          np[a] = mtts_sat($signed({dv_p.pos[a][CW-1], dv_p.pos[a]})
                         + $signed({sq[a][CW-1], sq[a]}));
        end
        out_d.write_position = 1'b1;
      end
    end
    out_d.new_pos_x = np[0];
    out_d.new_pos_y = np[1];
    out_d.new_pos_z = np[2];
    out_d.vel_x     = vel[0];
    out_d.vel_y     = vel[1];
    out_d.vel_z     = vel[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // a body velocity beat is either a snap (both writes, done) or a move
  `MTTS_ASSERT_IMP(a_vel_mode, out_valid_o && out_data_o.write_velocity,
    out_data_o.write_position != out_data_o.still_active, "velocity beat inconsistent")
  `MTTS_ASSERT_IMP(a_pos_zero, out_valid_o && !out_data_o.write_position,
    out_data_o.new_pos_x == '0 && out_data_o.new_pos_y == '0 && out_data_o.new_pos_z == '0,
    "position not zero without write")
  `MTTS_ASSERT_IMP(a_vel_zero, out_valid_o && !out_data_o.write_velocity,
    out_data_o.vel_x == '0 && out_data_o.vel_y == '0 && out_data_o.vel_z == '0,
    "velocity not zero without write")
  `MTTS_ASSERT_NXT(a_stall_hold, out_valid_o && !out_ready_i, out_valid_o,
    "result dropped while stalled")

endmodule

`default_nettype wire

/* hw/rtl/mtts_sqrt.sv */
// ----------------------------------------------------------------------------
// mtts_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtts_sqrt
  import mtts_pkg::*;
#(
  parameter int PW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [2*CW-1:0] rad_i,
  input  wire logic [PW-1:0]   pl_i,
  output logic                 valid_o,
  output logic [CW-1:0]        root_o,
  output logic [PW-1:0]        pl_o
);

  logic            v_q    [CW];
  logic [CW:0]     rem_q  [CW];
  logic [CW-1:0]   root_q [CW];
  logic [2*CW-1:0] rad_q  [CW];
  logic [PW-1:0]   pl_q   [CW];

  for (genvar s = 0; s < CW; s++) begin : g_stage
    logic            v_p;
    logic [CW:0]     rem_p;
    logic [CW-1:0]   root_p;
    logic [2*CW-1:0] rad_p;
    logic [PW-1:0]   pl_p;
    logic [CW+2:0]   rem_sh;
    logic [CW+2:0]   trial;
    logic            ge;

    if (s == 0) begin : g_first
      assign v_p    = valid_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
      assign pl_p   = pl_i;
    end else begin : g_rest
      assign v_p    = v_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
      assign rad_p  = rad_q[s-1];
      assign pl_p   = pl_q[s-1];
    end

    assign rem_sh = {rem_p, rad_p[2*CW-1 -: 2]};
    assign trial  = {1'b0, root_p, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_p;
      end
    end

    // remainder stays below 2*root + 1, so it needs CW+1 bits
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? (CW+1)'(rem_sh - trial) : rem_sh[CW:0];
        root_q[s] <= {root_p[CW-2:0], ge};
        rad_q[s]  <= {rad_p[2*CW-3:0], 2'b00};
        pl_q[s]   <= pl_p;
      end
    end
  end

  assign valid_o = v_q[CW-1];
  assign root_o  = root_q[CW-1];
  assign pl_o    = pl_q[CW-1];

endmodule

`default_nettype wire

/* hw/rtl/mtts_div.sv */
// ----------------------------------------------------------------------------
// mtts_div
// Three-lane pipelined restoring divider, shared divisor, one quotient bit
// per stage. The quotient is known to stay below 2^(CW-1).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtts_div
  import mtts_pkg::*;
#(
  parameter int PW = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [2:0][2*CW-3:0]  num_i,
  input  wire logic [CW-1:0]         den_i,
  input  wire logic [PW-1:0]         pl_i,
  output logic                       valid_o,
  output logic [2:0][CW-2:0]         quo_o,
  output logic [PW-1:0]              pl_o
);

  localparam int NS = CW - 1;

  logic                  v_q   [NS];
  logic [2:0][2*CW-2:0]  acc_q [NS];
  logic [CW-1:0]         den_q [NS];
  logic [PW-1:0]         pl_q  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic                 v_p;
    logic [2:0][2*CW-2:0] acc_p;
    logic [CW-1:0]        den_p;
    logic [PW-1:0]        pl_p;
    logic [2:0][2*CW-2:0] acc_n;

    if (s == 0) begin : g_first
      assign v_p   = valid_i;
      assign acc_p = {{1'b0, num_i[2]}, {1'b0, num_i[1]}, {1'b0, num_i[0]}};
      assign den_p = den_i;
      assign pl_p  = pl_i;
    end else begin : g_rest
      assign v_p   = v_q[s-1];
      assign acc_p = acc_q[s-1];
      assign den_p = den_q[s-1];
      assign pl_p  = pl_q[s-1];
    end

    always_comb begin
      logic [2*CW-1:0] sh;
      logic [CW:0]     top;
      logic            ge;
      for (int l = 0; l < 3; l++) begin
        sh  = {acc_p[l], 1'b0};
        top = sh[2*CW-1:CW-1];
        ge  = top >= {1'b0, den_p};
        if (ge) top = top - {1'b0, den_p};
        acc_n[l] = {top[CW-1:0], sh[CW-2:1], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[s] <= acc_n;
        den_q[s] <= den_p;
        pl_q[s]  <= pl_p;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign pl_o    = pl_q[NS-1];
  for (genvar l = 0; l < 3; l++) begin : g_quo
    assign quo_o[l] = acc_q[NS-1][l][CW-2:0];
  end

endmodule

`default_nettype wire
